// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
// Depends on nothing; the using module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PTPC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("periodic_task_pending_counter assertion failed");

// Property checked on every clock edge, reset included.
`define PTPC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("periodic_task_pending_counter assertion failed");

`endif

// ===== hw/rtl/ptpc_pkg.sv =====
// Package for the periodic task pending counter: sizes, codes and the
// control and status types passed between the top level and the slots.
// Depends on nothing.
package ptpc_pkg;

    // Number of task slots (1 to 8).
    localparam int NUM_SLOTS = 8;

    // Field and register widths.
    localparam int CNT_W      = 16;
    localparam int SLOT_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;

    // Saturation value of a pending count.
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // Request action codes.
    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_TAKE = 1'b1
    } t_action;

    // Per-slot control strobes, already qualified by the slot being active.
    typedef struct packed {
        logic tick;
        logic take;
    } t_slot_ctrl;

    // Per-slot status.
    typedef struct packed {
        logic [CNT_W-1:0] pending;
        logic             next_nonzero;
    } t_slot_stat;

endpackage

// ===== hw/rtl/ptpc_slot.sv =====
// One task slot: elapsed tick counter and saturating pending count.
// Depends on ptpc_pkg.
module ptpc_slot import ptpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_period,
    input  t_slot_ctrl       i_ctrl,
    output t_slot_stat       o_stat
);

    logic [CNT_W-1:0] r_elapsed;
    logic [CNT_W-1:0] r_pending;
    logic [CNT_W-1:0] n_elapsed;
    logic [CNT_W-1:0] n_pending;
    logic [CNT_W-1:0] w_inc;
    logic             w_fire;

    // The counter fires when the incremented count reaches or passes the period.
    assign w_inc  = r_elapsed + CNT_W'(1);
    assign w_fire = (w_inc >= i_period);

    // Next values for a tick, a take, or no change.
    always_comb begin
        n_elapsed = r_elapsed;
        n_pending = r_pending;
        if (i_ctrl.tick) begin
            if (w_fire) begin
                n_elapsed = '0;
                if (r_pending != CNT_MAX) begin
                    n_pending = r_pending + CNT_W'(1);
                end
            end else begin
                n_elapsed = w_inc;
            end
        end else if (i_ctrl.take) begin
            n_pending = '0;
        end
    end

    // Slot state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_pending <= '0;
        end else begin
            r_elapsed <= n_elapsed;
            r_pending <= n_pending;
        end
    end

    assign o_stat.pending      = r_pending;
    assign o_stat.next_nonzero = (n_pending != '0);

endmodule

// ===== hw/rtl/periodic_task_pending_counter.sv =====
// Periodic task pending counter, top level. A request is accepted into an
// input register and moves on into the result register when that register
// is free; one request per cycle is sustained while the result is not
// stalled, because all slots update in parallel.
// Synchronous active-low reset clears periods, counters and valid flags.
module periodic_task_pending_counter import ptpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CNT_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [SLOT_IDX_W-1:0] i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CNT_W-1:0]      o_taken_count,
    output logic                  o_any_pending
);

    logic [CNT_W-1:0]      r_period [NUM_SLOTS];
    logic                  r_s1_valid;
    t_action               r_s1_action;
    logic [SLOT_IDX_W-1:0] r_s1_slot;
    logic                  r_out_valid;
    logic [CNT_W-1:0]      r_taken;
    logic                  r_any;

    logic                  w_out_free;
    logic                  w_adv;
    logic [NUM_SLOTS-1:0]  w_active;
    t_slot_ctrl            w_ctrl [NUM_SLOTS];
    t_slot_stat            w_stat [NUM_SLOTS];
    logic [CNT_W-1:0]      n_taken;
    logic                  n_any;

    // Period registers; writes to indexes without a slot are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_period[i] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i)) begin
                    r_period[i] <= i_cfg_data;
                end
            end
        end
    end

    // Active slots are the leading run of nonzero periods.
    always_comb begin
        w_active[0] = (r_period[0] != '0);
        for (int i = 1; i < NUM_SLOTS; i++) begin
            w_active[i] = w_active[i-1] && (r_period[i] != '0);
        end
    end

    // Handshake: the input register moves on when the result register is free.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_action <= t_action'(i_action);
            r_s1_slot   <= i_slot_index;
        end
    end

    // Slot strobes for the request in the input register.
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_ctrl[i].tick = w_adv && (r_s1_action == ACT_TICK) && w_active[i];
            w_ctrl[i].take = w_adv && (r_s1_action == ACT_TAKE) && w_active[i]
                             && (r_s1_slot == SLOT_IDX_W'(i));
        end
    end

    // Task slots.
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
        ptpc_slot u_slot (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_period (r_period[g]),
            .i_ctrl   (w_ctrl[g]),
            .o_stat   (w_stat[g])
        );
    end

    // Taken count selected by the one-hot take strobes; pending flag after update.
    always_comb begin
        n_taken = '0;
        n_any   = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (w_ctrl[i].take) begin
                n_taken = n_taken | w_stat[i].pending;
            end
            n_any = n_any | (w_active[i] && w_stat[i].next_nonzero);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_taken <= n_taken;
            r_any   <= n_any;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_taken_count = r_taken;
    assign o_any_pending = r_any;

endmodule

// ===== hw/rtl/ptpc_checker.sv =====
// Port-level checker for the periodic task pending counter, bound to the top.
// Depends on ptpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptpc_checker import ptpc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [CNT_W-1:0]      o_taken_count,
    input logic                  o_any_pending
);

    // A stalled result stays valid.
    `PTPC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid)

    // A stalled result keeps its fields.
    `PTPC_ASSERT(a_data_hold, o_out_valid && i_out_stall |=> $stable({o_taken_count, o_any_pending}))

    // Reset empties the result register.
    `PTPC_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_out_valid)

    // Input stalls only behind a stalled result.
    `PTPC_ASSERT(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall)

    // A new result follows an accepted request through the input register and the result register.
    `PTPC_ASSERT(a_latency, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))

endmodule

bind periodic_task_pending_counter ptpc_checker u_ptpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_taken_count (o_taken_count),
    .o_any_pending (o_any_pending)
);
